// File: rtl/swre_pkg.sv
// Shared types and constants of the RMS envelope unit.
`default_nettype none
package swre_pkg;
	localparam int SAMPLE_BITS = 16;
	localparam int DIFF_BITS   = SAMPLE_BITS + 1;
	localparam int SQ_BITS     = 2 * SAMPLE_BITS;
	localparam int MEAN_BITS   = SQ_BITS;
	localparam int RMS_BITS    = 16;

	localparam logic [7:0] RADIUS_RESET = 8'd250;

	localparam logic CFG_RADIUS = 1'b0;
	localparam logic CFG_OFFSET = 1'b1;

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_FLUSH  = 1'b1;

	typedef struct packed {
		logic                          mode;
		logic signed [SAMPLE_BITS-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [RMS_BITS-1:0] rms_value;
		logic                last;
	} out_item_t;

	typedef struct packed {
		logic                        is_sample;
		logic signed [DIFF_BITS-1:0] diff;
	} cmd_t;
endpackage
`default_nettype wire

// File: rtl/swre_front.sv
// Input stage: accepts items, removes the baseline and classifies them.
`default_nettype none
module swre_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  swre_pkg::in_item_t                    in_item,
	input  logic signed [swre_pkg::SAMPLE_BITS-1:0] offset,
	output logic                                  cmd_valid,
	input  logic                                  cmd_full,
	output swre_pkg::cmd_t                        cmd
);
	logic           fr_valid_q;
	swre_pkg::cmd_t fr_q;
	logic           fr_move;

	assign fr_move   = fr_valid_q && !cmd_full;
	assign in_stall  = fr_valid_q && cmd_full;
	assign cmd_valid = fr_valid_q;
	assign cmd       = fr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_valid_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			fr_valid_q <= 1'b1;
		end else if (fr_move) begin
			fr_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			fr_q.is_sample <= (in_item.mode == swre_pkg::MODE_SAMPLE);
			fr_q.diff      <= swre_pkg::DIFF_BITS'(in_item.sample)
				- swre_pkg::DIFF_BITS'(offset);
		end
	end
endmodule
`default_nettype wire

// File: rtl/swre_queue.sv
// Two-entry queue between the input stage and the compute engine.
`default_nettype none
module swre_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  swre_pkg::cmd_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output swre_pkg::cmd_t head
);
	swre_pkg::cmd_t slot_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_item;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop) else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

// File: rtl/swre_back.sv
// Compute engine: sample ring, running sum, serial divider and square root.
`default_nettype none
module swre_back #(
	parameter int MAX_RADIUS = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  swre_pkg::cmd_t      q_item,
	output logic                q_pop,
	input  logic [7:0]          radius,
	output logic                out_valid,
	input  logic                out_stall,
	output swre_pkg::out_item_t out_item
);
	localparam int DEPTH = 2 * MAX_RADIUS + 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(MAX_RADIUS + 1);
	localparam int SW    = swre_pkg::SQ_BITS + AW;
	localparam int CW    = $clog2(SW + 1);
	localparam int DB    = swre_pkg::DIFF_BITS;

	typedef enum logic [2:0] {
		S_IDLE, S_SQ, S_ADD, S_DIV, S_SQRT, S_RM1, S_RM2, S_EMIT
	} state_t;

	state_t                       state_q;
	swre_pkg::cmd_t               cur_q;
	logic signed [DB-1:0]         ring [DEPTH];
	logic signed [DB-1:0]         rd_q;
	logic [swre_pkg::SQ_BITS-1:0] sq_q;
	logic [SW-1:0]                sum_q;
	logic [AW-1:0]                wc_q;
	logic [AW-1:0]                pend_q;
	logic [AW-1:0]                wp_q;
	logic [RW-1:0]                ract_q;
	logic [SW-1:0]                div_q;
	logic [AW-1:0]                rem_q;
	logic [CW-1:0]                cnt_q;
	logic [swre_pkg::MEAN_BITS-1:0] op_q;
	logic [swre_pkg::MEAN_BITS-1:0] res_q;
	logic [swre_pkg::MEAN_BITS-1:0] bit_q;
	logic                         rm_q;
	logic                         out_valid_q;
	swre_pkg::out_item_t          out_q;

	logic signed [DB-1:0]         mul_a;
	logic signed [2*DB-1:0]       prod;
	logic [31:0]                  rclamp;
	logic [31:0]                  old_pos;
	logic [AW-1:0]                raddr;
	logic [AW:0]                  trial;
	logic                         qbit;
	logic [AW-1:0]                rem_next;
	logic [SW-1:0]                div_next;
	logic [swre_pkg::MEAN_BITS-1:0] sq_try;
	logic                         rm_cond;
	logic                         emit_go;
	logic                         pend_over;

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign emit_go   = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	always_comb begin
		mul_a  = (state_q == S_RM1) ? rd_q : cur_q.diff;
		prod   = mul_a * mul_a;
		rclamp = (32'(radius) > 32'(MAX_RADIUS)) ? 32'(MAX_RADIUS) : 32'(radius);
		old_pos = 32'(wp_q) + 32'(DEPTH) - 32'(wc_q);
		if (old_pos >= 32'(DEPTH)) old_pos = old_pos - 32'(DEPTH);
		raddr = old_pos[AW-1:0];
		trial = {rem_q, div_q[SW-1]};
		qbit  = (trial >= {1'b0, wc_q});
		rem_next = qbit ? AW'(trial - {1'b0, wc_q}) : trial[AW-1:0];
		div_next = {div_q[SW-2:0], qbit};
		sq_try   = res_q + bit_q;
		rm_cond  = (wc_q >= pend_q) && (32'(wc_q - pend_q) >= 32'(ract_q)) && (wc_q != '0);
		pend_over = (32'(pend_q) + 32'd1) > 32'(ract_q);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SQ) ring[wp_q] <= cur_q.diff;
		rd_q <= ring[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sum_q       <= '0;
			wc_q        <= '0;
			pend_q      <= '0;
			wp_q        <= '0;
			ract_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_q <= q_item;
						div_q <= sum_q;
						rem_q <= '0;
						cnt_q <= '0;
						if (q_item.is_sample) begin
							if (wc_q == '0 && pend_q == '0) ract_q <= rclamp[RW-1:0];
							state_q <= S_SQ;
						end else if (pend_q != '0) begin
							state_q <= S_DIV;
						end
					end
				end
				S_SQ: begin
					sq_q    <= prod[swre_pkg::SQ_BITS-1:0];
					state_q <= S_ADD;
				end
				S_ADD: begin
					sum_q  <= sum_q + SW'(sq_q);
					div_q  <= sum_q + SW'(sq_q);
					wc_q   <= wc_q + 1'b1;
					pend_q <= pend_q + 1'b1;
					wp_q   <= (32'(wp_q) == DEPTH - 1) ? '0 : wp_q + 1'b1;
					state_q <= pend_over ? S_DIV : S_IDLE;
				end
				S_DIV: begin
					div_q <= div_next;
					rem_q <= rem_next;
					cnt_q <= cnt_q + 1'b1;
					if (32'(cnt_q) == SW - 1) begin
						op_q    <= div_next[swre_pkg::MEAN_BITS-1:0];
						res_q   <= '0;
						bit_q   <= {2'b01, {(swre_pkg::MEAN_BITS - 2){1'b0}}};
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (bit_q == '0) begin
						state_q <= S_RM1;
					end else begin
						if (op_q >= sq_try) begin
							op_q  <= op_q - sq_try;
							res_q <= (res_q >> 1) + bit_q;
						end else begin
							res_q <= res_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				S_RM1: begin
					rm_q    <= rm_cond;
					sq_q    <= prod[swre_pkg::SQ_BITS-1:0];
					state_q <= S_RM2;
				end
				S_RM2: begin
					if (rm_q) begin
						sum_q <= sum_q - SW'(sq_q);
						wc_q  <= wc_q - 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						out_q.rms_value <= res_q[swre_pkg::RMS_BITS-1:0];
						out_q.last      <= (pend_q == AW'(1));
						if (pend_q == AW'(1)) begin
							sum_q  <= '0;
							wc_q   <= '0;
							pend_q <= '0;
							wp_q   <= '0;
						end else begin
							pend_q <= pend_q - 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && pend_q == AW'(1)) |=> (wc_q == '0 && pend_q == '0))
		else $error("window not emptied after last item");
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pend_q) <= 32'(ract_q) + 32'd1)
		else $error("more results owed than the radius allows");
	a_wc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wc_q) <= 2 * 32'(ract_q) + 32'd1)
		else $error("window wider than its radius allows");
	a_emit_owed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (pend_q != '0))
		else $error("result produced with nothing owed");
`endif
endmodule
`default_nettype wire

// File: rtl/sliding_window_rms_envelope_unit.sv
// Top level of the centered moving RMS envelope unit.
`default_nettype none
// Channel   Direction  Handshake            Item
// in        input      in_valid / in_stall   in_item (mode, sample)
// out       output     out_valid / out_stall out_item (rms_value, last)
// cfg       input      cfg_we                cfg_index, cfg_data
//
// The engine squares each sample into the running sum; an item owing a result
// then runs a one-bit-per-cycle divider over the 41-bit sum, a 16-step square
// root and a removal of the oldest sample from the window. Flush items owing
// nothing are dropped. Reset clears the window, the queue and the output register.
// A two-entry queue lets the input stage keep taking items while the engine runs,
// and the output register holds a finished result while out_stall is high.
module sliding_window_rms_envelope_unit #(
	parameter int MAX_RADIUS = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  swre_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output swre_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data
);
	// Configuration registers. Radius is latched by the engine at the first
	// sample of a record; the offset is applied as each sample arrives.
	logic [7:0]                                radius_q;
	logic signed [swre_pkg::SAMPLE_BITS-1:0]   offset_q;

	logic           cmd_valid;
	logic           q_full;
	swre_pkg::cmd_t cmd;
	logic           q_not_empty;
	logic           q_pop;
	swre_pkg::cmd_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= swre_pkg::RADIUS_RESET;
			offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				swre_pkg::CFG_RADIUS: radius_q <= cfg_data[7:0];
				swre_pkg::CFG_OFFSET: offset_q <= cfg_data;
				default: radius_q <= radius_q;
			endcase
		end
	end

	// Front end: one register that subtracts the baseline and tags the item.
	swre_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.offset    (offset_q),
		.cmd_valid (cmd_valid),
		.cmd_full  (q_full),
		.cmd       (cmd)
	);

	// Decoupling queue between the front end and the engine.
	swre_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_valid && !q_full),
		.push_item (cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Engine: owns the sample ring, the window sums and the output register.
	swre_back #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_item    (q_head),
		.q_pop     (q_pop),
		.radius    (radius_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);
endmodule
`default_nettype wire

// File: verif/envelope_checker.sv
// Checker for the RMS envelope unit: watches the channels, predicts results and compares them.
`timescale 1ns / 100ps
module envelope_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  swre_pkg::in_item_t  in_item,
	input  logic                out_valid,
	input  logic                out_stall,
	input  swre_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data,
	output int                  results_owed,
	output int                  fail_count
);
	localparam int RADIUS_MAX = 255;
	localparam int RING_SIZE  = 2 * RADIUS_MAX + 2;

	longint    ring [RING_SIZE];
	longint    energy;
	int        fill;
	int        owed;
	int        head;
	int        held_radius;
	int        radius_reg;
	int        offset_reg;
	swre_pkg::out_item_t envelope_q[$];

	function automatic longint sq(longint d);
		return d * d;
	endfunction

	function automatic longint root_floor(longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	task automatic empty_window();
		energy = 0;
		fill   = 0;
		owed   = 0;
		head   = 0;
	endtask

	task automatic emit_envelope();
		swre_pkg::out_item_t e;
		longint    m;
		m = (fill != 0) ? energy / fill : 0;
		m = root_floor(m);
		e.rms_value = (m > 65535) ? 16'hFFFF : m[15:0];
		e.last      = 1'b0;
		if (fill >= owed && fill - owed >= held_radius && fill > 0) begin
			energy -= sq(ring[(head + RING_SIZE - fill) % RING_SIZE]);
			fill--;
		end
		if (owed > 0) owed--;
		if (owed == 0) begin
			e.last = 1'b1;
			empty_window();
		end
		envelope_q = {envelope_q, e};
	endtask

	task automatic predict_item(swre_pkg::in_item_t it);
		longint d;
		if (it.mode == swre_pkg::MODE_SAMPLE) begin
			if (fill == 0 && owed == 0)
				held_radius = (radius_reg > RADIUS_MAX) ? RADIUS_MAX : radius_reg;
			d = longint'(it.sample) - offset_reg;
			ring[head] = d;
			head = (head + 1) % RING_SIZE;
			energy += sq(d);
			fill++;
			owed++;
			if (owed > held_radius) emit_envelope();
		end else if (owed != 0) begin
			emit_envelope();
		end
	endtask

	task automatic report(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	assign results_owed = envelope_q.size();

	always @(posedge clk or negedge arst_n) begin
		swre_pkg::out_item_t e;
		if (!arst_n) begin
			empty_window();
			held_radius = 0;
			radius_reg  = swre_pkg::RADIUS_RESET;
			offset_reg  = 0;
			fail_count  = 0;
			envelope_q.delete();
		end else begin
			// The output side is checked before the input side predicts new work.
			if (out_valid && !out_stall) begin
				if (envelope_q.size() == 0) begin
					report("result with nothing expected, rms_value", out_item.rms_value, -1);
				end else begin
					e = envelope_q.pop_front();
					if (out_item.rms_value !== e.rms_value)
						report("rms_value", out_item.rms_value, e.rms_value);
					if (out_item.last !== e.last)
						report("last", out_item.last, e.last);
				end
			end
			if (in_valid && !in_stall) predict_item(in_item);
			if (cfg_we) begin
				if (cfg_index == swre_pkg::CFG_RADIUS) radius_reg = cfg_data[7:0];
				else offset_reg = int'($signed(cfg_data));
			end
		end
	end
endmodule

// File: verif/testbench.sv
// Top of the RMS envelope testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	swre_pkg::in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	swre_pkg::out_item_t out_item;
	logic      cfg_we = 1'b0;
	logic      cfg_index = swre_pkg::CFG_RADIUS;
	logic [15:0] cfg_data = '0;
	int        results_owed;
	int        fail_count;

	// Percentages of idle sender cycles and stalled receiver cycles.
	int        idle_pct = 0;
	int        stall_pct = 0;
	int        radius_now = swre_pkg::RADIUS_RESET;
	int        items_sent = 0;

	always #10 clk = ~clk;

	sliding_window_rms_envelope_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	envelope_checker env_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.results_owed(results_owed), .fail_count(fail_count)
	);

	// The receiver stalls at random with the current stall percentage.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Offers one item and returns right after the edge that accepts it. Valid is
	// only lowered when the sender idles, so back-to-back items keep it high.
	// The stall is looked at on the falling edge, where it is stable.
	task automatic send(logic mode, logic [15:0] value);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		in_valid       <= 1'b1;
		in_item.mode   <= mode;
		in_item.sample <= value;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		items_sent++;
	endtask

	// Stops the sender until every expected result has come, then lets the
	// engine finish any item that owes no result.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Registers are only written once the block has gone quiet.
	task automatic write_reg(logic index, logic [15:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (index == swre_pkg::CFG_RADIUS) radius_now = value[7:0];
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// One record of n samples followed by enough flush items to drain it, plus
	// up to two more that owe nothing. A stray flush inside the record is rare.
	task automatic play_record(int n, bit stray_flush);
		int owed_guess;
		for (int k = 0; k < n; k++) begin
			if (stray_flush && $urandom_range(9) == 0)
				send(swre_pkg::MODE_FLUSH, 16'($urandom));
			send(swre_pkg::MODE_SAMPLE, pick_sample());
		end
		owed_guess = (n < radius_now) ? n : radius_now;
		for (int k = 0; k < owed_guess + $urandom_range(2); k++)
			send(swre_pkg::MODE_FLUSH, 16'($urandom));
	endtask

	initial begin
		#30ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int phase;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. First a short record at the reset radius, so every
		// result comes from the flush items and the window is cut at both ends.
		play_record(4, 1'b0);
		// Largest radius, extreme samples against extreme offsets. The two
		// extra flush items close the record that the two lone samples opened.
		write_reg(swre_pkg::CFG_RADIUS, 16'd255);
		write_reg(swre_pkg::CFG_OFFSET, 16'h8000);
		send(swre_pkg::MODE_SAMPLE, 16'h7FFF);
		send(swre_pkg::MODE_SAMPLE, 16'h8000);
		play_record(1, 1'b0);
		send(swre_pkg::MODE_FLUSH, 16'h0000);
		send(swre_pkg::MODE_FLUSH, 16'h0000);
		write_reg(swre_pkg::CFG_OFFSET, 16'h7FFF);
		play_record(3, 1'b0);
		// A radius of zero gives a one-sample window and a result per sample.
		write_reg(swre_pkg::CFG_RADIUS, 16'd0);
		write_reg(swre_pkg::CFG_OFFSET, 16'd0);
		play_record(4, 1'b0);
		// Flush with nothing owed produces nothing.
		send(swre_pkg::MODE_FLUSH, 16'hFFFF);
		// Smallest nonzero radius with a record long enough to slide the window.
		write_reg(swre_pkg::CFG_RADIUS, 16'd1);
		play_record(6, 1'b0);

		// Random part in four idling phases.
		phase = 0;
		while (items_sent < 800) begin
			case (items_sent / 200)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 75; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 75; end
				default: begin idle_pct = 26; stall_pct = 26; end
			endcase
			if ($urandom_range(9) == 0)
				write_reg(swre_pkg::CFG_RADIUS, 16'($urandom_range(255, 200)));
			else if ($urandom_range(3) == 0)
				write_reg(swre_pkg::CFG_RADIUS, 16'($urandom_range(6)));
			if ($urandom_range(3) == 0)
				write_reg(swre_pkg::CFG_OFFSET, ($urandom_range(4) == 0) ? pick_sample()
					: 16'($urandom_range(400) - 200));
			// Large radii get short records to keep the run short.
			if (radius_now > 8) play_record($urandom_range(12), 1'b0);
			else play_record($urandom_range(3 * radius_now + 3), $urandom_range(4) == 0);
			phase++;
		end

		drain();
		repeat (300) @(posedge clk);
		if (fail_count == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule

// File: sliding_window_rms_envelope_unit.f
rtl/swre_pkg.sv
rtl/swre_front.sv
rtl/swre_queue.sv
rtl/swre_back.sv
rtl/sliding_window_rms_envelope_unit.sv
verif/envelope_checker.sv
verif/testbench.sv
